// ----- rtl/lasf_pkg.sv -----
// Shared types, register codes and byte helpers for the line-aware substring finder.
`default_nettype none

package lasf_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LO     = 4'd0,
    REG_PATTERN_HI     = 4'd1,
    REG_PATTERN_LENGTH = 4'd2,
    REG_MATCH_CASE     = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic shift_en;
    logic match_case;
  } cell_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic match_case);
    logic [7:0] r;
    r = c;
    if (!match_case && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [7:0] pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
                                               input logic [6:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (idx < 7'd8) begin
      r = lo[{idx[2:0], 3'b000} +: 8];
    end else if (idx < 7'd16) begin
      r = hi[{idx[2:0], 3'b000} +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lasf_in_if.sv -----
// Text input channel carrying one byte per transaction.
`default_nettype none

interface lasf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_start;

  modport source (output valid, output text_byte, output text_start, input ready);
  modport sink   (input valid, input text_byte, input text_start, output ready);
endinterface

`default_nettype wire

// ----- rtl/lasf_out_if.sv -----
// Match result channel carrying one match report per transaction.
`default_nettype none

interface lasf_out_if #(
  parameter int POS_W = 24
);
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] match_index;
  logic [POS_W-1:0] line_number;
  logic [POS_W-1:0] start_position;
  logic [POS_W-1:0] end_position;

  modport source (output valid, output match_index, output line_number,
                  output start_position, output end_position, input ready);
  modport sink   (input valid, input match_index, input line_number,
                  input start_position, input end_position, output ready);
endinterface

`default_nettype wire

// ----- rtl/lasf_cfg_if.sv -----
// Configuration write channel carrying a register index and write data.
`default_nettype none

interface lasf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lasf_pkg::CFG_INDEX_W-1:0] reg_index;
  logic [lasf_pkg::CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/lasf_cell.sv -----
// One window cell: holds a recent text byte, passes it on and compares it with its pattern byte.
`default_nettype none

module lasf_cell (
  input  logic                 clk,
  input  lasf_pkg::cell_ctrl_t ctrl,
  input  logic                 active,
  input  logic [7:0]           byte_in,
  input  logic [7:0]           pat_byte,
  output logic [7:0]           byte_out,
  output logic                 cell_ok
);
  import lasf_pkg::*;

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign cell_ok  = !active ||
                    (fold_byte(byte_r, ctrl.match_case) == fold_byte(pat_byte, ctrl.match_case));

endmodule

`default_nettype wire

// ----- rtl/line_aware_substring_finder_core.sv -----
// Top level of the line-aware substring finder: window cell chain, counters and result buffer.
//
// Text bytes arrive on in_chan, one byte per transaction; text_start marks the first byte of a
// new text and clears the position, line and match counters. Each accepted byte is compared
// against the configured pattern in the same cycle by a chain of window cells, each holding one
// recent byte. A match is registered into the result buffer and reported on out_chan from its head entry.
// Bytes that complete no match produce no transaction.
// The block takes one byte every cycle; the only limit is the two-entry result buffer, which
// lets input continue while one result waits and holds in_chan.ready low only when both
// entries are full under a stalled receiver.
// The pattern, its length and the case mode are written through cfg_chan, which is always
// ready, and should only be changed while no text is in flight.
// Reset clears the configuration to an empty pattern, clears all counters and empties the
// result buffer; the text is taken to begin at reset.
`default_nettype none

module line_aware_substring_finder_core #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  lasf_in_if.sink     in_chan,
  lasf_out_if.source  out_chan,
  lasf_cfg_if.sink    cfg_chan
);
  import lasf_pkg::*;

  localparam int WIN   = MAX_PATTERN - 1;
  localparam int CELLS = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = POSITION_BITS;

  typedef struct packed {
    logic [POS_W-1:0] match_index;
    logic [POS_W-1:0] line_number;
    logic [POS_W-1:0] start_position;
    logic [POS_W-1:0] end_position;
  } result_t;

  logic [63:0]      pattern_lo_r;
  logic [63:0]      pattern_hi_r;
  logic [4:0]       pattern_length_r;
  logic             match_case_r;

  logic [LEN_W-1:0] run_r, run_nxt, run_base;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_base;
  logic [POS_W-1:0] line_r, line_nxt, line_base;
  logic [POS_W-1:0] match_r, match_nxt, match_base;

  logic             head_v_r, head_v_nxt, skid_v_r, skid_v_nxt;
  result_t          head_r, skid_r, res;
  logic             load_head_in, load_head_skid, load_skid;

  logic             in_fire, pop, push;
  logic [LEN_W-1:0] len_c;
  logic             is_nl, run_ok, head_eq, hit;
  logic [7:0]       text_c;
  logic [POS_W-1:0] len_m1;
  cell_ctrl_t       cell_ctrl;
  logic [7:0]       win_bytes [CELLS];
  logic [CELLS-1:0] cell_ok;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_lo_r     <= '0;
      pattern_hi_r     <= '0;
      pattern_length_r <= '0;
      match_case_r     <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        REG_PATTERN_LO:     pattern_lo_r     <= cfg_chan.wr_data;
        REG_PATTERN_HI:     pattern_hi_r     <= cfg_chan.wr_data;
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_chan.wr_data[4:0];
        REG_MATCH_CASE:     match_case_r     <= cfg_chan.wr_data[0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = !skid_v_r;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign text_c        = in_chan.text_byte;
  assign is_nl         = (text_c == NEWLINE_CHAR);

  assign len_c = (int'(pattern_length_r) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN)
                                                         : LEN_W'(pattern_length_r);

  assign run_base   = in_chan.text_start ? '0 : run_r;
  assign pos_base   = in_chan.text_start ? '0 : pos_r;
  assign line_base  = in_chan.text_start ? '0 : line_r;
  assign match_base = in_chan.text_start ? '0 : match_r;

  assign run_ok  = (int'(run_base) + 1) >= int'(len_c);
  assign head_eq = fold_byte(text_c, match_case_r) ==
                   fold_byte(pattern_byte(pattern_lo_r, pattern_hi_r, 7'(len_c) - 7'd1),
                             match_case_r);
  assign hit     = !is_nl && (len_c != '0) && run_ok && head_eq && (&cell_ok);

  assign cell_ctrl.shift_en   = in_fire && !is_nl && !hit;
  assign cell_ctrl.match_case = match_case_r;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    logic [7:0] cell_in;
    logic       cell_active;

    if (k == 0) begin : g_first
      assign cell_in = text_c;
    end else begin : g_next
      assign cell_in = win_bytes[k-1];
    end

    assign cell_active = int'(len_c) > (k + 1);

    lasf_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .active   (cell_active),
      .byte_in  (cell_in),
      .pat_byte (pattern_byte(pattern_lo_r, pattern_hi_r, 7'(len_c) - 7'(k + 2))),
      .byte_out (win_bytes[k]),
      .cell_ok  (cell_ok[k])
    );
  end

  assign len_m1 = POS_W'(len_c) - POS_W'(1);

  always_comb begin
    res.match_index    = match_base;
    res.line_number    = (&line_base) ? line_base : line_base + POS_W'(1);
    res.start_position = (pos_base >= len_m1) ? pos_base - len_m1 : '0;
    res.end_position   = pos_base;
  end

  always_comb begin
    run_nxt   = run_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    match_nxt = match_r;
    if (in_fire) begin
      pos_nxt   = (&pos_base) ? pos_base : pos_base + POS_W'(1);
      line_nxt  = line_base;
      match_nxt = match_base;
      if (is_nl) begin
        run_nxt  = '0;
        line_nxt = (&line_base) ? line_base : line_base + POS_W'(1);
      end else if (hit) begin
        run_nxt   = '0;
        match_nxt = (&match_base) ? match_base : match_base + POS_W'(1);
      end else if (int'(run_base) < WIN) begin
        run_nxt = run_base + LEN_W'(1);
      end else begin
        run_nxt = run_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      pos_r   <= '0;
      line_r  <= '0;
      match_r <= '0;
    end else begin
      run_r   <= run_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      match_r <= match_nxt;
    end
  end

  assign push = in_fire && hit;
  assign pop  = head_v_r && out_chan.ready;

  always_comb begin
    head_v_nxt     = head_v_r;
    skid_v_nxt     = skid_v_r;
    load_head_in   = 1'b0;
    load_head_skid = 1'b0;
    load_skid      = 1'b0;
    if (pop) begin
      if (skid_v_r) begin
        load_head_skid = 1'b1;
        skid_v_nxt     = 1'b0;
      end else begin
        head_v_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!head_v_nxt) begin
        head_v_nxt   = 1'b1;
        load_head_in = 1'b1;
      end else begin
        skid_v_nxt = 1'b1;
        load_skid  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_head_skid) begin
      head_r <= skid_r;
    end else if (load_head_in) begin
      head_r <= res;
    end
    if (load_skid) begin
      skid_r <= res;
    end
  end

  assign out_chan.valid          = head_v_r;
  assign out_chan.match_index    = head_r.match_index;
  assign out_chan.line_number    = head_r.line_number;
  assign out_chan.start_position = head_r.start_position;
  assign out_chan.end_position   = head_r.end_position;

endmodule

`default_nettype wire

// ----- rtl/lasf_checker.sv -----
// Port-level checks for the line-aware substring finder, bound to its top level.
`default_nettype none

module lasf_checker #(
  parameter int MAX_PATTERN = 16,
  parameter int POS_W       = 24
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] line_number,
  input logic [POS_W-1:0] start_position,
  input logic [POS_W-1:0] end_position
);

  logic [POS_W-1:0] span;
  assign span = end_position - start_position;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result withdrawn before its transaction completed.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(end_position) && $stable(line_number))
    else $error("Stalled result changed.");

  a_rise_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("Result appeared without an input transaction.");

  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (end_position >= start_position) && (int'(span) < MAX_PATTERN))
    else $error("Match span exceeds the pattern window.");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (line_number != '0))
    else $error("Line number of a match is zero.");

endmodule

bind line_aware_substring_finder_core lasf_checker #(
  .MAX_PATTERN (MAX_PATTERN),
  .POS_W       (POSITION_BITS)
) u_lasf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .line_number    (out_chan.line_number),
  .start_position (out_chan.start_position),
  .end_position   (out_chan.end_position)
);

`default_nettype wire
